/* rtl/core/sbp_pkg.sv */
// Shared types and constants for the ramped bin positioner.
package sbp_pkg;

   localparam int unsigned WaitWidth  = 9;
   localparam int unsigned StepWidth  = 8;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   // Hold periods reloaded at phase 0 before the sensor is looked at (on top of
   // the first one, which the command item loads).
   localparam logic [StepWidth-1:0] HoldPeriods = 8'd3;

   typedef enum logic [1:0] {
      FUNC_TICK = 2'd0,
      FUNC_MOVE = 2'd1,
      FUNC_HOME = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_PATTERN_TABLE = 3'd0,
      CSR_BASE_DELAY    = 3'd1,
      CSR_RAMP_STEPS    = 3'd2,
      CSR_QUARTER_STEPS = 3'd3,
      CSR_HOME_PERIOD   = 3'd4
   } csr_index_type;

   localparam logic [31:0] PatternTableReset = 32'h352D_2E36;
   localparam logic [7:0]  BaseDelayReset    = 8'd6;
   localparam logic [5:0]  RampStepsReset    = 6'd14;
   localparam logic [6:0]  QuarterStepsReset = 7'd50;
   localparam logic [7:0]  HomePeriodReset   = 8'd20;

   typedef struct packed {
      logic [1:0] func;
      logic [1:0] target_bin;
      logic       home_sensor;
   } item_type;

   typedef struct packed {
      logic [7:0] coil_pattern;
      logic       busy_res;
      logic [1:0] bin_position;
      logic       move_done;
   } result_type;

endpackage

/* rtl/core/stepper_bin_positioner_ramped.sv */
// Top level of the ramped stepper bin positioner: input and result registers.
//
// Usage
//   req_* carries one word per item: a 1 ms tick, a move command naming a
//   target bin, or a home command, with the hall sensor level. rsp_* returns
//   exactly one word per request word: coil byte, busy flag, bin under the
//   chute and a one-word finish pulse, all taken after that word's update.
//   csr_* writes the five settings registers (pattern table, base delay,
//   ramp steps, quarter steps, home period); write them only while idle.
// Timing
//   A word taken is held in the input register and is processed as it moves
//   into the result register, from which its response is shown. One word per
//   cycle is sustained while rsp_ready stays high; the update is a single pass of
//   counter, compare and add logic between the input and result registers.
// Reset
//   Synchronous reset clears both valid flags, the positioner state and
//   loads the settings defaults. No clearing sweep is needed.
// Stall
//   While rsp_ready is low the response holds; the input register still
//   takes one more word, then req_ready drops until the response moves.
module stepper_bin_positioner_ramped
   import sbp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_func,
   input  logic [1:0]              req_target_bin,
   input  logic                    req_home_sensor,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_coil_pattern,
   output logic                    rsp_busy_res,
   output logic [1:0]              rsp_bin_position,
   output logic                    rsp_move_done,
   input  logic                    csr_write_en,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       fire;

   // Move a word from the input register once the result register is free.
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff.func        <= req_func;
         in_item_ff.target_bin  <= req_target_bin;
         in_item_ff.home_sensor <= req_home_sensor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   sbp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fire         (fire),
      .item         (in_item_ff),
      .result       (result)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_coil_pattern = out_ff.coil_pattern;
   assign rsp_busy_res     = out_ff.busy_res;
   assign rsp_bin_position = out_ff.bin_position;
   assign rsp_move_done    = out_ff.move_done;

endmodule

/* rtl/core/sbp_core.sv */
// Positioner state, settings registers and the per-word update logic.
module sbp_core
   import sbp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_en,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   input  logic                    fire,
   input  item_type                item,
   output result_type              result
);

   logic [31:0] pattern_ff;
   logic [7:0]  base_ff;
   logic [5:0]  ramp_ff;
   logic [6:0]  quarter_ff;
   logic [7:0]  home_period_ff;

   logic [1:0]           phase_ff, phase_in;
   logic [1:0]           bin_ff, bin_in;
   logic [1:0]           goal_ff, goal_in;
   logic                 active_ff, active_in;
   logic                 homing_ff, homing_in;
   logic                 reverse_ff, reverse_in;
   logic [StepWidth-1:0] total_ff, total_in;
   logic [StepWidth-1:0] index_ff, index_in;
   logic [WaitWidth-1:0] wait_ff, wait_in;

   logic [1:0]           dist_bins;
   logic [StepWidth-1:0] cmd_total;
   logic [StepWidth-1:0] adv_i, adv_n;
   logic                 adv_rev;
   logic                 move_finish;
   logic [StepWidth-1:0] dist_end, dist_near, ramp_sel;
   logic [WaitWidth-1:0] move_wait, wait_dec;
   logic [1:0]           move_phase;
   logic                 done;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff     <= PatternTableReset;
         base_ff        <= BaseDelayReset;
         ramp_ff        <= RampStepsReset;
         quarter_ff     <= QuarterStepsReset;
         home_period_ff <= HomePeriodReset;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PATTERN_TABLE: pattern_ff     <= csr_wdata;
            CSR_BASE_DELAY:    base_ff        <= csr_wdata[7:0];
            CSR_RAMP_STEPS:    ramp_ff        <= csr_wdata[5:0];
            CSR_QUARTER_STEPS: quarter_ff     <= csr_wdata[6:0];
            CSR_HOME_PERIOD:   home_period_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         bin_ff     <= '0;
         goal_ff    <= '0;
         active_ff  <= 1'b0;
         homing_ff  <= 1'b0;
         reverse_ff <= 1'b0;
         total_ff   <= '0;
         index_ff   <= '0;
         wait_ff    <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         bin_ff     <= bin_in;
         goal_ff    <= goal_in;
         active_ff  <= active_in;
         homing_ff  <= homing_in;
         reverse_ff <= reverse_in;
         total_ff   <= total_in;
         index_ff   <= index_in;
         wait_ff    <= wait_in;
      end
   end

   // Step arithmetic, shared by the move command and by a tick that ends a wait.
   always_comb begin
      dist_bins = item.target_bin - bin_ff;
      cmd_total = (dist_bins == 2'd2) ? {quarter_ff, 1'b0} : {1'b0, quarter_ff};

      if (func_type'(item.func) == FUNC_MOVE) begin
         adv_i   = '0;
         adv_n   = cmd_total;
         adv_rev = (dist_bins == 2'd3);
      end else begin
         adv_i   = index_ff;
         adv_n   = total_ff;
         adv_rev = reverse_ff;
      end

      move_finish = (adv_i >= adv_n);
      dist_end    = adv_n - 8'd1 - adv_i;
      dist_near   = (adv_i < dist_end) ? adv_i : dist_end;
      ramp_sel    = ({2'b00, ramp_ff} > dist_near) ? ({2'b00, ramp_ff} - dist_near) : '0;
      move_wait   = {1'b0, base_ff} + {3'b000, ramp_sel[5:0]};
      move_phase  = adv_rev ? (phase_ff + 2'd3) : (phase_ff + 2'd1);
      wait_dec    = (wait_ff != '0) ? (wait_ff - 9'd1) : '0;
   end

   always_comb begin
      phase_in   = phase_ff;
      bin_in     = bin_ff;
      goal_in    = goal_ff;
      active_in  = active_ff;
      homing_in  = homing_ff;
      reverse_in = reverse_ff;
      total_in   = total_ff;
      index_in   = index_ff;
      wait_in    = wait_ff;
      done       = 1'b0;

      unique case (func_type'(item.func))
         FUNC_TICK: begin
            if (active_ff) begin
               wait_in = wait_dec;
               if (wait_dec == '0) begin
                  if (homing_ff) begin
                     if (index_ff < HoldPeriods) begin
                        index_in = index_ff + 8'd1;
                        wait_in  = {1'b0, home_period_ff};
                     end else if (!item.home_sensor) begin
                        active_in = 1'b0;
                        homing_in = 1'b0;
                        bin_in    = '0;
                        goal_in   = '0;
                        done      = 1'b1;
                     end else begin
                        phase_in = phase_ff + 2'd1;
                        wait_in  = {1'b0, home_period_ff};
                     end
                  end else if (move_finish) begin
                     active_in = 1'b0;
                     bin_in    = goal_ff;
                     done      = 1'b1;
                  end else begin
                     phase_in = move_phase;
                     wait_in  = move_wait;
                     index_in = index_ff + 8'd1;
                  end
               end
            end
         end
         FUNC_MOVE: begin
            if (!active_ff && dist_bins != 2'd0) begin
               total_in   = cmd_total;
               reverse_in = adv_rev;
               goal_in    = item.target_bin;
               homing_in  = 1'b0;
               // first step goes on the command word itself
               if (move_finish) begin
                  active_in = 1'b0;
                  bin_in    = item.target_bin;
                  index_in  = '0;
                  wait_in   = '0;
                  done      = 1'b1;
               end else begin
                  active_in = 1'b1;
                  phase_in  = move_phase;
                  wait_in   = move_wait;
                  index_in  = 8'd1;
               end
            end
         end
         FUNC_HOME: begin
            if (!active_ff) begin
               phase_in  = '0;
               homing_in = 1'b1;
               active_in = 1'b1;
               index_in  = '0;
               wait_in   = {1'b0, home_period_ff};
            end
         end
         default: ;
      endcase

      result.coil_pattern = pattern_ff[{phase_in, 3'b000} +: 8];
      result.busy_res     = active_in;
      result.bin_position = bin_in;
      result.move_done    = done;
   end

   a_homing_active: assert property (@(posedge clock) disable iff (reset)
      homing_ff |-> active_ff)
      else $error("homing without an active operation");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      fire && result.move_done |=> !active_ff && !homing_ff)
      else $error("still busy after a finish pulse");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff && !homing_ff |-> index_ff <= total_ff)
      else $error("step index ran past the move length");

   a_idle_wait: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> wait_ff == '0)
      else $error("wait counter left running while idle");

endmodule

/* tb/tb_stepper_bin_positioner_ramped.sv */
// Self-checking testbench for the ramped stepper bin positioner.
`timescale 1ns / 100ps

module tb_stepper_bin_positioner_ramped;
   import sbp_pkg::*;

   localparam int CycleLimit  = 500000;
   localparam int DrainCycles = 4;
   localparam int RandomWords = 60;

   typedef struct packed {
      func_type   func;
      logic [1:0] target_bin;
      logic       home_sensor;
   } tray_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_func = FUNC_TICK;
   logic [1:0] req_target_bin = 2'd0;
   logic       req_home_sensor = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_coil_pattern;
   logic       rsp_busy_res;
   logic [1:0] rsp_bin_position;
   logic       rsp_move_done;
   logic                    csr_write_en = 1'b0;
   csr_index_type           csr_index = CSR_PATTERN_TABLE;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   // settings as the block should hold them
   logic [31:0] cfg_pattern = PatternTableReset;
   logic [7:0]  cfg_base = BaseDelayReset;
   logic [5:0]  cfg_ramp = RampStepsReset;
   logic [6:0]  cfg_quarter = QuarterStepsReset;
   logic [7:0]  cfg_home_period = HomePeriodReset;

   // positioner state as the block should hold it
   logic [1:0] phase = 2'd0;
   logic [1:0] bin_now = 2'd0;
   logic [1:0] bin_goal = 2'd0;
   logic       busy = 1'b0;
   logic       homing = 1'b0;
   logic       ccw = 1'b0;
   logic [7:0] steps_total = 8'd0;
   logic [7:0] step_idx = 8'd0;
   logic [9:0] wait_cnt = 10'd0;

   tray_word_type word_queue[$];
   result_type    tray_expected[$];
   tray_word_type drv_next;
   result_type    want_rsp;

   int words_pending = 0;
   int words_taken = 0;
   int results_seen = 0;
   int errors = 0;
   int moves_finished = 0;
   int homes_finished = 0;
   int settings_loaded = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   logic pressure_go = 1'b0;
   logic rsp_hold = 1'b0;

   stepper_bin_positioner_ramped u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_target_bin   (req_target_bin),
      .req_home_sensor  (req_home_sensor),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_coil_pattern (rsp_coil_pattern),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_bin_position (rsp_bin_position),
      .rsp_move_done    (rsp_move_done),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Take the next step of a move, or finish it once every step has waited out.
   function automatic bit motor_advance();
      int unsigned ends_gap;
      int unsigned ramp;
      if (step_idx >= steps_total) begin
         busy = 1'b0;
         bin_now = bin_goal;
         moves_finished++;
         return 1'b1;
      end
      phase = ccw ? phase - 2'd1 : phase + 2'd1;
      ends_gap = steps_total - 8'd1 - step_idx;
      if (step_idx < ends_gap) ends_gap = step_idx;
      ramp = (cfg_ramp > ends_gap) ? cfg_ramp - ends_gap : 0;
      wait_cnt = 10'(cfg_base + ramp);
      step_idx = step_idx + 8'd1;
      return 1'b0;
   endfunction

   function automatic result_type tray_predict(tray_word_type w);
      result_type r;
      bit done;
      logic [1:0] span;
      done = 1'b0;
      if (w.func == FUNC_TICK) begin
         if (busy) begin
            if (wait_cnt != 0) wait_cnt = wait_cnt - 10'd1;
            if (wait_cnt == 0) begin
               if (!homing) begin
                  done = motor_advance();
               end else if (step_idx < HoldPeriods) begin
                  step_idx = step_idx + 8'd1;
                  wait_cnt = 10'(cfg_home_period);
               end else if (!w.home_sensor) begin
                  busy = 1'b0;
                  homing = 1'b0;
                  bin_now = 2'd0;
                  bin_goal = 2'd0;
                  homes_finished++;
                  done = 1'b1;
               end else begin
                  phase = phase + 2'd1;
                  wait_cnt = 10'(cfg_home_period);
               end
            end
         end
      end else if (w.func == FUNC_MOVE && !busy) begin
         span = w.target_bin - bin_now;
         if (span != 2'd0) begin
            steps_total = (span == 2'd2) ? {cfg_quarter, 1'b0} : {1'b0, cfg_quarter};
            ccw = (span == 2'd3);
            bin_goal = w.target_bin;
            homing = 1'b0;
            busy = 1'b1;
            step_idx = 8'd0;
            wait_cnt = 10'd0;
            done = motor_advance();
         end
      end else if (w.func == FUNC_HOME && !busy) begin
         phase = 2'd0;
         homing = 1'b1;
         busy = 1'b1;
         step_idx = 8'd0;
         wait_cnt = 10'(cfg_home_period);
      end
      r.coil_pattern = cfg_pattern[8*phase +: 8];
      r.busy_res = busy;
      r.bin_position = bin_now;
      r.move_done = done;
      return r;
   endfunction

   task automatic flag_mismatch(string what, int got, int exp_val);
      $display("MISMATCH response %0d: %s got %0h expected %0h", results_seen, what, got,
               exp_val);
      errors++;
   endtask

   // Driver: offer words from the queue, predict each one as it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            tray_expected.push_back(tray_predict({func_type'(req_func), req_target_bin,
                                                  req_home_sensor}));
            words_pending--;
            words_taken++;
         end
         if (!req_valid || req_ready) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drv_next = word_queue.pop_front();
               req_valid <= 1'b1;
               req_func <= drv_next.func;
               req_target_bin <= drv_next.target_bin;
               req_home_sensor <= drv_next.home_sensor;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each response word against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (tray_expected.size() == 0) begin
               flag_mismatch("response with nothing expected", 0, 0);
            end else begin
               want_rsp = tray_expected.pop_front();
               if (rsp_coil_pattern !== want_rsp.coil_pattern)
                  flag_mismatch("coil_pattern", rsp_coil_pattern, want_rsp.coil_pattern);
               if (rsp_busy_res !== want_rsp.busy_res)
                  flag_mismatch("busy_res", rsp_busy_res, want_rsp.busy_res);
               if (rsp_bin_position !== want_rsp.bin_position)
                  flag_mismatch("bin_position", rsp_bin_position, want_rsp.bin_position);
               if (rsp_move_done !== want_rsp.move_done)
                  flag_mismatch("move_done", rsp_move_done, want_rsp.move_done);
            end
         end
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   // Long hold-off on the response side so the input backs up.
   initial begin
      wait (pressure_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send(func_type f, logic [1:0] tgt, logic sensor);
      word_queue.push_back({f, tgt, sensor});
      words_pending++;
   endtask

   task automatic wait_drained();
      while (words_pending != 0 || tray_expected.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Tick until the tray comes to rest; keep the sensor mostly low so homing ends.
   task automatic run_out();
      wait_drained();
      while (busy) begin
         repeat (32) send(FUNC_TICK, 2'($urandom_range(3)), $urandom_range(3) == 0);
         wait_drained();
      end
   endtask

   task automatic set_reg(csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_PATTERN_TABLE: cfg_pattern = val;
         CSR_BASE_DELAY:    cfg_base = val[7:0];
         CSR_RAMP_STEPS:    cfg_ramp = val[5:0];
         CSR_QUARTER_STEPS: cfg_quarter = val[6:0];
         CSR_HOME_PERIOD:   cfg_home_period = val[7:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic load_settings(logic [31:0] pat, logic [7:0] base, logic [5:0] ramp,
                                logic [6:0] quarter, logic [7:0] hper);
      run_out();
      set_reg(CSR_PATTERN_TABLE, pat);
      set_reg(CSR_BASE_DELAY, {24'd0, base});
      set_reg(CSR_RAMP_STEPS, {26'd0, ramp});
      set_reg(CSR_QUARTER_STEPS, {25'd0, quarter});
      set_reg(CSR_HOME_PERIOD, {24'd0, hper});
      settings_loaded++;
   endtask

   // One command followed by a run of ticks, with the odd stray command mixed in.
   task automatic episode();
      int pick;
      int ticks;
      pick = $urandom_range(99);
      if (pick < 65)
         send(FUNC_MOVE, 2'($urandom_range(3)), 1'($urandom_range(1)));
      else if (pick < 85)
         send(FUNC_HOME, 2'($urandom_range(3)), 1'($urandom_range(1)));
      else
         send(func_type'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)));
      ticks = $urandom_range(5, 60);
      repeat (ticks) begin
         if ($urandom_range(99) < 8)
            send(func_type'($urandom_range(3)), 2'($urandom_range(3)),
                 1'($urandom_range(1)));
         else
            send(FUNC_TICK, 2'($urandom_range(3)), $urandom_range(99) >= 40);
      end
   endtask

   initial begin
      int send_mix[4];
      int stall_mix[4];
      int start_words;
      send_mix = '{0, 49, 0, 20};
      stall_mix = '{0, 0, 49, 20};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // default settings: idle words, zero distance, commands while busy
      send(FUNC_TICK, 2'd3, 1'b1);
      send(FUNC_NONE, 2'd2, 1'b0);
      send(FUNC_MOVE, 2'd0, 1'b1);
      send(FUNC_MOVE, 2'd1, 1'b0);
      repeat (3) send(FUNC_TICK, 2'd1, 1'b0);
      send(FUNC_MOVE, 2'd3, 1'b0);
      send(FUNC_HOME, 2'd2, 1'b1);
      send(FUNC_NONE, 2'd3, 1'b1);
      // first steps on the default ramp, then shorten the waits mid-move
      repeat (60) send(FUNC_TICK, 2'd0, 1'b1);
      wait_drained();
      set_reg(CSR_BASE_DELAY, 32'd0);
      set_reg(CSR_RAMP_STEPS, 32'd1);
      run_out();
      // sensor low during the hold periods must be ignored
      send(FUNC_HOME, 2'd1, 1'b0);
      repeat (70) send(FUNC_TICK, 2'd0, 1'b0);
      repeat (30) send(FUNC_TICK, 2'd2, 1'b1);
      run_out();

      // zero delay: every step still costs a tick
      load_settings(32'h0000_0000, 8'd0, 6'd0, 7'd1, 8'd1);
      send(FUNC_MOVE, 2'd1, 1'b1);
      run_out();
      send(FUNC_HOME, 2'd0, 1'b1);
      run_out();
      // longest single wait
      load_settings(32'hFFFF_FFFF, 8'd255, 6'd63, 7'd1, 8'd2);
      send(FUNC_MOVE, 2'd3, 1'b0);
      run_out();
      send(FUNC_HOME, 2'd3, 1'b1);
      run_out();
      // longest move, short ramp at both ends
      load_settings($urandom, 8'd0, 6'd3, 7'd127, 8'd1);
      send(FUNC_MOVE, 2'd2, 1'b0);
      run_out();
      // zero step count finishes on the command word itself
      load_settings($urandom, 8'd1, 6'd2, 7'd0, 8'd3);
      send(FUNC_MOVE, 2'd1, 1'b0);
      send(FUNC_MOVE, 2'd1, 1'b1);
      send(FUNC_MOVE, 2'd2, 1'b0);
      run_out();

      for (int ph = 0; ph < 4; ph++) begin
         load_settings($urandom, 8'($urandom_range(0, 3)), 6'($urandom_range(0, 4)),
                       7'($urandom_range(1, 6)), 8'($urandom_range(1, 4)));
         @(posedge clock);
         send_idle_pct <= send_mix[ph];
         stall_pct <= stall_mix[ph];
         if (ph == 0) pressure_go = 1'b1;
         start_words = words_taken + words_pending;
         while (words_taken + words_pending - start_words < RandomWords) episode();
      end
      run_out();

      if (tray_expected.size() != 0)
         flag_mismatch("predictions left over", tray_expected.size(), 0);
      $display("Checked %0d responses for %0d request words over %0d settings loads",
               results_seen, words_taken, settings_loaded);
      $display("%0d moves and %0d homing runs completed, under four idle and stall mixes",
               moves_finished, homes_finished);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
